/* design/fatlb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fatlb_pkg;

   localparam int DEF_ENTRIES   = 8;
   localparam int DEF_PAGE_BITS = 20;
   localparam int COUNT_BITS    = 32;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_FILL   = 1'b1;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_LRU  = 1'b1;

   typedef struct packed {
      logic capture;
      logic execute;
      logic publish;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctl_sts_type;

endpackage

`default_nettype wire

/* design/fatlb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fatlb_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/fatlb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module fatlb_ctrl
   import fatlb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ctl_sts_type ctl_sts,
   output ctl_cmd_type      ctl_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready       = (state_ff == ST_IDLE);
   assign ctl_cmd.capture = req_valid && req_ready;
   assign ctl_cmd.execute = (state_ff == ST_EXEC);
   assign ctl_cmd.publish = (state_ff == ST_DONE) && ctl_sts.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl_cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctl_sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* design/fatlb_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module fatlb_dpath
   import fatlb_pkg::*;
#(
   parameter int ENTRIES   = DEF_ENTRIES,
   parameter int PAGE_BITS = DEF_PAGE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ctl_cmd_type           ctl_cmd,
   output ctl_sts_type                ctl_sts,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data,
   input  wire logic                  req_command,
   input  wire logic [PAGE_BITS-1:0]  req_vpage,
   input  wire logic [PAGE_BITS-1:0]  req_frame_in,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic      [PAGE_BITS-1:0]  rsp_frame_out,
   output logic      [COUNT_BITS-1:0] rsp_miss_count,
   output logic      [COUNT_BITS-1:0] rsp_lookup_count
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   logic                  policy_ff;
   logic                  cmd_ff;
   logic [PAGE_BITS-1:0]  vpage_ff;
   logic [PAGE_BITS-1:0]  frame_ff;
   logic [PAGE_BITS-1:0]  tag_ff [ENTRIES];
   logic [PAGE_BITS-1:0]  tag_in [ENTRIES];
   idx_type               rank_ff [ENTRIES];
   idx_type               rank_in [ENTRIES];
   cnt_type               fill_cnt_ff;
   cnt_type               fill_cnt_in;
   idx_type               ins_ptr_ff;
   idx_type               ins_ptr_in;
   logic [COUNT_BITS-1:0] miss_ff;
   logic [COUNT_BITS-1:0] miss_in;
   logic [COUNT_BITS-1:0] look_ff;
   logic [COUNT_BITS-1:0] look_in;
   logic                  hit_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [PAGE_BITS-1:0]  rsp_frame_ff;
   logic [COUNT_BITS-1:0] rsp_miss_ff;
   logic [COUNT_BITS-1:0] rsp_look_ff;

   logic [ENTRIES-1:0]    valid;
   logic [ENTRIES-1:0]    match;
   logic                  any_hit;
   idx_type               hit_idx;
   idx_type               lru_idx;
   idx_type               victim;
   idx_type               wr_idx;
   logic                  full;
   logic                  is_lookup;
   logic                  is_fill;
   logic                  mr_en;
   idx_type               mr_idx;
   idx_type               mr_old;
   idx_type               mr_top;
   logic [PAGE_BITS-1:0]  ram_rd_data;

   assign is_lookup = ctl_cmd.execute && (cmd_ff == CMD_LOOKUP);
   assign is_fill   = ctl_cmd.execute && (cmd_ff == CMD_FILL);
   assign full      = (fill_cnt_ff == cnt_type'(ENTRIES));
   assign any_hit   = |match;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         valid[i] = (cnt_type'(i) < fill_cnt_ff);
         match[i] = valid[i] && (tag_ff[i] == vpage_ff);
      end
   end

   always_comb begin
      hit_idx = '0;
      lru_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = idx_type'(i);
         end
         if (rank_ff[i] == '0) begin
            lru_idx = idx_type'(i);
         end
      end
   end

   assign victim = (policy_ff == POLICY_LRU) ? lru_idx : ins_ptr_ff;
   assign wr_idx = full ? victim : fill_cnt_ff[IDX_W-1:0];

   assign mr_en  = (is_lookup && any_hit && (policy_ff == POLICY_LRU)) || (is_fill && full);
   assign mr_idx = is_fill ? victim : hit_idx;
   assign mr_old = rank_ff[mr_idx];
   assign mr_top = idx_type'(fill_cnt_ff - 1'b1);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         tag_in[i]  = tag_ff[i];
         rank_in[i] = rank_ff[i];
         if (mr_en) begin
            if (idx_type'(i) == mr_idx) begin
               rank_in[i] = mr_top;
            end else if (valid[i] && (rank_ff[i] > mr_old)) begin
               rank_in[i] = rank_ff[i] - 1'b1;
            end
         end
         if (is_fill && (idx_type'(i) == wr_idx)) begin
            tag_in[i] = vpage_ff;
            if (!full) begin
               rank_in[i] = idx_type'(fill_cnt_ff);
            end
         end
      end
   end

   always_comb begin
      fill_cnt_in = fill_cnt_ff;
      ins_ptr_in  = ins_ptr_ff;
      miss_in     = miss_ff;
      look_in     = look_ff;
      if (is_fill && !full) begin
         fill_cnt_in = fill_cnt_ff + 1'b1;
      end
      if (is_fill && full && (policy_ff == POLICY_FIFO)) begin
         ins_ptr_in = (ins_ptr_ff == idx_type'(ENTRIES - 1)) ? '0 : ins_ptr_ff + 1'b1;
      end
      if (is_lookup) begin
         look_in = look_ff + 1'b1;
         if (!any_hit) begin
            miss_in = miss_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl_cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign ctl_sts.out_free = !rsp_valid_ff || rsp_ready;

   fatlb_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (ENTRIES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (is_fill),
      .wr_addr (wr_idx),
      .wr_data (frame_ff),
      .rd_en   (is_lookup && any_hit),
      .rd_addr (hit_idx),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff    <= POLICY_FIFO;
         fill_cnt_ff  <= '0;
         ins_ptr_ff   <= '0;
         miss_ff      <= '0;
         look_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
         fill_cnt_ff  <= fill_cnt_in;
         ins_ptr_ff   <= ins_ptr_in;
         miss_ff      <= miss_in;
         look_ff      <= look_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         tag_ff[i] <= tag_in[i];
      end
      if (ctl_cmd.capture) begin
         cmd_ff   <= req_command;
         vpage_ff <= req_vpage;
         frame_ff <= req_frame_in;
      end
      if (ctl_cmd.execute) begin
         hit_ff <= is_lookup && any_hit;
      end
      if (ctl_cmd.publish) begin
         rsp_hit_ff   <= hit_ff;
         rsp_frame_ff <= hit_ff ? ram_rd_data : '0;
         rsp_miss_ff  <= miss_ff;
         rsp_look_ff  <= look_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame_out    = rsp_frame_ff;
   assign rsp_miss_count   = rsp_miss_ff;
   assign rsp_lookup_count = rsp_look_ff;

endmodule

`default_nettype wire

/* design/fully_assoc_tlb_fifo_lru_core.sv */
//  Channel    Ports                                   Direction
//  request    req_valid/req_ready, req_* payload      in
//  response   rsp_valid/rsp_ready, rsp_* payload      out
//  csr        csr_wr_en, csr_wr_data                  in, no wait
//
//  An item passes through accept, tag match and table update, then result load.
//  The tag compare over all entries and the registered frame RAM read set these steps.
//  A stalled response holds the load step; no new request is accepted meanwhile.
//  Reset is synchronous; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fully_assoc_tlb_fifo_lru_core
   import fatlb_pkg::*;
#(
   parameter int ENTRIES   = DEF_ENTRIES,
   parameter int PAGE_BITS = DEF_PAGE_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_command,
   input  wire logic [PAGE_BITS-1:0]  req_vpage,
   input  wire logic [PAGE_BITS-1:0]  req_frame_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_hit,
   output logic      [PAGE_BITS-1:0]  rsp_frame_out,
   output logic      [COUNT_BITS-1:0] rsp_miss_count,
   output logic      [COUNT_BITS-1:0] rsp_lookup_count
);

   ctl_cmd_type ctl_cmd;
   ctl_sts_type ctl_sts;

   fatlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .ctl_sts   (ctl_sts),
      .ctl_cmd   (ctl_cmd)
   );

   fatlb_dpath #(
      .ENTRIES   (ENTRIES),
      .PAGE_BITS (PAGE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl_cmd          (ctl_cmd),
      .ctl_sts          (ctl_sts),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_command      (req_command),
      .req_vpage        (req_vpage),
      .req_frame_in     (req_frame_in),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_frame_out    (rsp_frame_out),
      .rsp_miss_count   (rsp_miss_count),
      .rsp_lookup_count (rsp_lookup_count)
   );

endmodule

`default_nettype wire

/* design/fatlb_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module fatlb_checker
   import fatlb_pkg::*;
#(
   parameter int PAGE_BITS = DEF_PAGE_BITS
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic                  rsp_hit,
   input wire logic [PAGE_BITS-1:0]  rsp_frame_out,
   input wire logic [COUNT_BITS-1:0] rsp_miss_count
);

   a_rst_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_miss_count))
      else $error("stalled response changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_frame_out == '0)
      else $error("frame nonzero without a hit");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

endmodule

bind fully_assoc_tlb_fifo_lru_core fatlb_checker #(
   .PAGE_BITS (PAGE_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hit        (rsp_hit),
   .rsp_frame_out  (rsp_frame_out),
   .rsp_miss_count (rsp_miss_count)
);

`default_nettype wire
